>>> hw/rtl/nearest_palette_color_mapper_unit_assert.svh
`ifndef NEAREST_PALETTE_COLOR_MAPPER_UNIT_ASSERT_SVH
`define NEAREST_PALETTE_COLOR_MAPPER_UNIT_ASSERT_SVH

// Clocked assertion, checked outside reset.
`define NPCM_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Clocked assertion, checked during reset as well.
`define NPCM_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

>>> hw/rtl/npcm_pkg.sv
`timescale 1ns / 1ps

package npcm_pkg;

   localparam int PALETTE_ENTRIES_DEF = 256;
   localparam int STORE_DEPTH         = 256;

   localparam int COLOR_W = 8;
   localparam int INDEX_W = 8;
   localparam int RGB_W   = 3 * COLOR_W;
   localparam int SQ_W    = 2 * COLOR_W;
   localparam int DIST_W  = 18;
   localparam int BEST_W  = 20;
   localparam int COUNT_W = 9;

   localparam logic [BEST_W-1:0] DIST_START = BEST_W'(999999);

   typedef enum logic [1:0] {
      FUNC_CLEAR = 2'd0,
      FUNC_WRITE = 2'd1,
      FUNC_LEARN = 2'd2,
      FUNC_MAP   = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_LEARN_WR,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic load;
      logic scan;
      logic learn_wr;
      logic resp_load;
   } ctrl_cmd_type;

   typedef struct packed {
      func_type func;
      logic     scan_done;
      logic     out_free;
   } dp_status_type;

   function automatic logic [COLOR_W-1:0] abs_diff(input logic [COLOR_W-1:0] a,
                                                   input logic [COLOR_W-1:0] b);
      abs_diff = (a > b) ? (a - b) : (b - a);
   endfunction

endpackage

>>> hw/rtl/npcm_ram.sv
`timescale 1ns / 1ps

module npcm_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/npcm_ctrl.sv
`timescale 1ns / 1ps
`include "nearest_palette_color_mapper_unit_assert.svh"

module npcm_ctrl
   import npcm_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  logic [1:0]    req_func,
   output logic          req_ready,
   input  dp_status_type status,
   output ctrl_cmd_type  cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               unique case (func_type'(req_func))
                  FUNC_CLEAR, FUNC_WRITE: state_in = ST_RESP;
                  FUNC_LEARN, FUNC_MAP:   state_in = ST_SCAN;
                  default:                state_in = ST_RESP;
               endcase
            end
         end
         ST_SCAN: begin
            if (status.scan_done) begin
               state_in = (status.func == FUNC_LEARN) ? ST_LEARN_WR : ST_RESP;
            end
         end
         ST_LEARN_WR: state_in = ST_RESP;
         ST_RESP: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready     = (state_ff == ST_IDLE);
      cmd.load      = (state_ff == ST_IDLE) && req_valid;
      cmd.scan      = (state_ff == ST_SCAN);
      cmd.learn_wr  = (state_ff == ST_LEARN_WR);
      cmd.resp_load = (state_ff == ST_RESP) && status.out_free;
   end

   `NPCM_ASSERT(a_learn_wr_then_resp, cmd.learn_wr |=> state_ff == ST_RESP, "learn write not followed by response")
   `NPCM_ASSERT(a_map_skips_learn_wr, (state_ff == ST_SCAN && status.func == FUNC_MAP) |=> state_ff != ST_LEARN_WR, "map entered learn write")
   `NPCM_ASSERT(a_one_command, $onehot0({cmd.load, cmd.scan, cmd.learn_wr, cmd.resp_load}), "overlapping datapath commands")

endmodule

>>> hw/rtl/npcm_datapath.sv
`timescale 1ns / 1ps
`include "nearest_palette_color_mapper_unit_assert.svh"

module npcm_datapath
   import npcm_pkg::*;
#(
   parameter int PALETTE_ENTRIES = PALETTE_ENTRIES_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  ctrl_cmd_type        cmd,
   output dp_status_type       status,
   input  logic [1:0]          req_func,
   input  logic [INDEX_W-1:0]  req_entry_index,
   input  logic [COLOR_W-1:0]  req_red,
   input  logic [COLOR_W-1:0]  req_green,
   input  logic [COLOR_W-1:0]  req_blue,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [INDEX_W-1:0]  rsp_best_index,
   output logic [DIST_W-1:0]   rsp_min_dist,
   output logic                rsp_added,
   output logic                rsp_palette_full,
   output logic [COUNT_W-1:0]  rsp_learned_count
);

   localparam int AW = $clog2(PALETTE_ENTRIES);
   localparam logic [COUNT_W-1:0] N_CNT = COUNT_W'(PALETTE_ENTRIES);

   // Item held for the duration of the operation.
   func_type            op_ff;
   logic [RGB_W-1:0]    rgb_ff;
   logic [INDEX_W-1:0]  res_idx_ff;
   logic [BEST_W-1:0]   best_ff;
   logic                found_ff;
   logic                added_ff;
   logic [COUNT_W-1:0]  learned_ff;
   logic [PALETTE_ENTRIES-1:0] valid_ff;

   // Scan pipeline: address issue, memory read, squares, compare.
   logic [COUNT_W-1:0]  cnt_ff;
   logic                s1_vld_ff;
   logic [AW-1:0]       s1_idx_ff;
   logic                s1_ent_vld_ff;
   logic                s2_vld_ff;
   logic [AW-1:0]       s2_idx_ff;
   logic                s2_match_ff;
   logic [SQ_W-1:0]     sqr_ff;
   logic [SQ_W-1:0]     sqg_ff;
   logic [SQ_W-1:0]     sqb_ff;

   logic                rsp_valid_ff;
   logic [INDEX_W-1:0]  rsp_idx_ff;
   logic [DIST_W-1:0]   rsp_dist_ff;
   logic                rsp_added_ff;
   logic                rsp_full_ff;
   logic [COUNT_W-1:0]  rsp_count_ff;

   logic                do_clear;
   logic                wr_direct;
   logic                do_add;
   logic                ram_wr_en;
   logic [AW-1:0]       ram_wr_addr;
   logic [RGB_W-1:0]    ram_wr_data;
   logic [RGB_W-1:0]    ram_rd_data;
   logic [COUNT_W-1:0]  scan_limit;
   logic                issue;
   logic [RGB_W-1:0]    ent;
   logic [COLOR_W-1:0]  dr;
   logic [COLOR_W-1:0]  dg;
   logic [COLOR_W-1:0]  db;
   logic [DIST_W-1:0]   sq_dist;

   assign do_clear  = cmd.load && (func_type'(req_func) == FUNC_CLEAR);
   assign wr_direct = cmd.load && (func_type'(req_func) == FUNC_WRITE)
                      && ({1'b0, req_entry_index} < N_CNT);
   assign do_add    = !found_ff && (learned_ff < N_CNT);

   always_comb begin
      ram_wr_en   = 1'b0;
      ram_wr_addr = req_entry_index[AW-1:0];
      ram_wr_data = {req_red, req_green, req_blue};
      if (wr_direct) begin
         ram_wr_en = 1'b1;
      end else if (cmd.learn_wr && do_add) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = learned_ff[AW-1:0];
         ram_wr_data = rgb_ff;
      end
   end

   assign scan_limit = (op_ff == FUNC_MAP) ? N_CNT : learned_ff;
   assign issue      = cmd.scan && (cnt_ff < scan_limit);

   npcm_ram #(
      .WIDTH (RGB_W),
      .DEPTH (PALETTE_ENTRIES)
   ) u_palette (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (issue),
      .rd_addr (cnt_ff[AW-1:0]),
      .rd_data (ram_rd_data)
   );

   // An entry never written since the last clear reads as black.
   assign ent  = s1_ent_vld_ff ? ram_rd_data : '0;
   assign dr   = abs_diff(rgb_ff[RGB_W-1 -: COLOR_W], ent[RGB_W-1 -: COLOR_W]);
   assign dg   = abs_diff(rgb_ff[2*COLOR_W-1 -: COLOR_W], ent[2*COLOR_W-1 -: COLOR_W]);
   assign db   = abs_diff(rgb_ff[COLOR_W-1:0], ent[COLOR_W-1:0]);
   assign sq_dist = DIST_W'(sqr_ff) + DIST_W'(sqg_ff) + DIST_W'(sqb_ff);

   always_ff @(posedge clock) begin
      if (reset || do_clear) begin
         valid_ff   <= '0;
         learned_ff <= '0;
      end else begin
         if (ram_wr_en) begin
            valid_ff[ram_wr_addr] <= 1'b1;
         end
         if (cmd.learn_wr && do_add) begin
            learned_ff <= learned_ff + COUNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= issue;
         s2_vld_ff <= s1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_idx_ff     <= cnt_ff[AW-1:0];
      s1_ent_vld_ff <= valid_ff[cnt_ff[AW-1:0]];
      s2_idx_ff     <= s1_idx_ff;
      s2_match_ff   <= (ent == rgb_ff);
      sqr_ff        <= dr * dr;
      sqg_ff        <= dg * dg;
      sqb_ff        <= db * db;
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff      <= func_type'(req_func);
         rgb_ff     <= {req_red, req_green, req_blue};
         res_idx_ff <= (func_type'(req_func) == FUNC_WRITE) ? req_entry_index : '0;
         best_ff    <= DIST_START;
         found_ff   <= 1'b0;
         added_ff   <= 1'b0;
         cnt_ff     <= '0;
      end else begin
         if (issue) begin
            cnt_ff <= cnt_ff + COUNT_W'(1);
         end
         if (s2_vld_ff) begin
            if (op_ff == FUNC_MAP) begin
               // Strict compare keeps the lowest index on a tie.
               if (BEST_W'(sq_dist) < best_ff) begin
                  best_ff    <= BEST_W'(sq_dist);
                  res_idx_ff <= INDEX_W'(s2_idx_ff);
               end
            end else if (s2_match_ff && !found_ff) begin
               found_ff   <= 1'b1;
               res_idx_ff <= INDEX_W'(s2_idx_ff);
            end
         end
         if (cmd.learn_wr && do_add) begin
            res_idx_ff <= learned_ff[INDEX_W-1:0];
            added_ff   <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.resp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.resp_load) begin
         rsp_idx_ff   <= res_idx_ff;
         rsp_dist_ff  <= (op_ff == FUNC_MAP) ? best_ff[DIST_W-1:0] : '0;
         rsp_added_ff <= added_ff;
         rsp_full_ff  <= (learned_ff >= N_CNT);
         rsp_count_ff <= learned_ff;
      end
   end

   assign status.func      = op_ff;
   assign status.scan_done = (cnt_ff >= scan_limit) && !s1_vld_ff && !s2_vld_ff;
   assign status.out_free  = !rsp_valid_ff || rsp_ready;

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_best_index    = rsp_idx_ff;
   assign rsp_min_dist      = rsp_dist_ff;
   assign rsp_added         = rsp_added_ff;
   assign rsp_palette_full  = rsp_full_ff;
   assign rsp_learned_count = rsp_count_ff;

   `NPCM_ASSERT(a_learned_bounded, learned_ff <= N_CNT, "learned count beyond palette size")
   `NPCM_ASSERT(a_resp_slot_free, cmd.resp_load |-> (!rsp_valid_ff || rsp_ready), "result overwritten before taken")
   `NPCM_ASSERT(a_no_write_while_scan, (s1_vld_ff || s2_vld_ff) |-> !ram_wr_en, "palette written during scan")

endmodule

>>> hw/rtl/nearest_palette_color_mapper_unit.sv
`timescale 1ns / 1ps
// Channel  Direction  Handshake            Word
// req      in         req_valid/req_ready  func, entry_index, red, green, blue
// rsp      out        rsp_valid/rsp_ready  best_index, min_dist, added,
//                                          palette_full, learned_count
//
// Map reads every palette entry and learn only the learned ones, one palette entry
// read per cycle. Reset is synchronous; the palette reads as all zero after reset or
// clear, with no clearing pass. A new word is taken while the previous result waits
// on rsp_ready; a stalled result holds the block only once the next result is ready.

module nearest_palette_color_mapper_unit
   import npcm_pkg::*;
#(
   parameter int PALETTE_ENTRIES = PALETTE_ENTRIES_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [1:0]          req_func,
   input  logic [INDEX_W-1:0]  req_entry_index,
   input  logic [COLOR_W-1:0]  req_red,
   input  logic [COLOR_W-1:0]  req_green,
   input  logic [COLOR_W-1:0]  req_blue,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [INDEX_W-1:0]  rsp_best_index,
   output logic [DIST_W-1:0]   rsp_min_dist,
   output logic                rsp_added,
   output logic                rsp_palette_full,
   output logic [COUNT_W-1:0]  rsp_learned_count
);

   ctrl_cmd_type  cmd;
   dp_status_type status;

   npcm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_func  (req_func),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   npcm_datapath #(
      .PALETTE_ENTRIES (PALETTE_ENTRIES)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_func          (req_func),
      .req_entry_index   (req_entry_index),
      .req_red           (req_red),
      .req_green         (req_green),
      .req_blue          (req_blue),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_best_index    (rsp_best_index),
      .rsp_min_dist      (rsp_min_dist),
      .rsp_added         (rsp_added),
      .rsp_palette_full  (rsp_palette_full),
      .rsp_learned_count (rsp_learned_count)
   );

endmodule

>>> verif/nearest_palette_color_mapper_unit_checker.sv
`timescale 1ns / 1ps

module nearest_palette_color_mapper_unit_checker
   import npcm_pkg::*;
#(
   parameter int PALETTE_ENTRIES = PALETTE_ENTRIES_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic [1:0]         req_func,
   input  logic [INDEX_W-1:0] req_entry_index,
   input  logic [COLOR_W-1:0] req_red,
   input  logic [COLOR_W-1:0] req_green,
   input  logic [COLOR_W-1:0] req_blue,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic [INDEX_W-1:0] rsp_best_index,
   input  logic [DIST_W-1:0]  rsp_min_dist,
   input  logic               rsp_added,
   input  logic               rsp_palette_full,
   input  logic [COUNT_W-1:0] rsp_learned_count,
   output int                 mismatch_count,
   output int                 words_in_flight
);

   typedef struct packed {
      logic [INDEX_W-1:0] best_index;
      logic [DIST_W-1:0]  min_dist;
      logic               added;
      logic               palette_full;
      logic [COUNT_W-1:0] learned_count;
   } palette_answer_type;

   logic [RGB_W-1:0]   palette_copy [STORE_DEPTH];
   logic [COUNT_W-1:0] learned_copy;
   palette_answer_type awaited_answers [$];
   int                 mismatches = 0;
   int                 in_flight = 0;

   assign mismatch_count  = mismatches;
   assign words_in_flight = in_flight;

   function automatic int channel_sq(input logic [COLOR_W-1:0] a, input logic [COLOR_W-1:0] b);
      int d;
      d = int'(a) - int'(b);
      return d * d;
   endfunction

   // Applies one request word to the local palette copy and returns the answer it must produce.
   task automatic apply_palette_word(input func_type f, input logic [INDEX_W-1:0] idx,
                                     input logic [COLOR_W-1:0] r, input logic [COLOR_W-1:0] g,
                                     input logic [COLOR_W-1:0] b,
                                     output palette_answer_type ans);
      int               slots;
      int               limit;
      int               sq_sum;
      int               nearest;
      logic             found;
      logic [RGB_W-1:0] color;
      slots = (PALETTE_ENTRIES > STORE_DEPTH) ? STORE_DEPTH : PALETTE_ENTRIES;
      color = {r, g, b};
      ans   = '0;
      case (f)
         FUNC_CLEAR: begin
            foreach (palette_copy[i]) palette_copy[i] = '0;
            learned_copy = '0;
         end
         FUNC_WRITE: begin
            if (int'(idx) < slots) palette_copy[idx] = color;
            ans.best_index = idx;
         end
         FUNC_LEARN: begin
            found = 1'b0;
            limit = (int'(learned_copy) < slots) ? int'(learned_copy) : slots;
            // Only slots that were learned are searched, lowest match first.
            for (int i = 0; i < limit && !found; i++) begin
               if (palette_copy[i] == color) begin
                  found          = 1'b1;
                  ans.best_index = INDEX_W'(i);
               end
            end
            if (!found && int'(learned_copy) < slots) begin
               palette_copy[learned_copy[INDEX_W-1:0]] = color;
               ans.best_index = learned_copy[INDEX_W-1:0];
               ans.added      = 1'b1;
               learned_copy   = learned_copy + 1'b1;
            end
         end
         default: begin
            nearest = int'(DIST_START);
            for (int i = 0; i < slots; i++) begin
               sq_sum = channel_sq(r, palette_copy[i][23:16])
                      + channel_sq(g, palette_copy[i][15:8])
                      + channel_sq(b, palette_copy[i][7:0]);
               if (sq_sum < nearest) begin
                  nearest        = sq_sum;
                  ans.best_index = INDEX_W'(i);
               end
            end
            ans.min_dist = DIST_W'(nearest);
         end
      endcase
      ans.palette_full  = (int'(learned_copy) >= slots);
      ans.learned_count = learned_copy;
   endtask

   task automatic compare_field(input string name, input int want_v, input int got_v);
      if (want_v != got_v) begin
         $error("%s mismatch: expected %0d, actual %0d", name, want_v, got_v);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      palette_answer_type want;
      palette_answer_type fresh;
      if (reset) begin
         foreach (palette_copy[i]) palette_copy[i] = '0;
         learned_copy = '0;
         awaited_answers.delete();
      end else begin
         // Results leave before the word accepted at this same edge can produce one.
         if (rsp_valid && rsp_ready) begin
            if (awaited_answers.size() == 0) begin
               $error("result word with no request waiting: best_index %0d", rsp_best_index);
               mismatches++;
            end else begin
               want = awaited_answers.pop_front();
               compare_field("best_index", want.best_index, rsp_best_index);
               compare_field("min_dist", want.min_dist, rsp_min_dist);
               compare_field("added", want.added, rsp_added);
               compare_field("palette_full", want.palette_full, rsp_palette_full);
               compare_field("learned_count", want.learned_count, rsp_learned_count);
            end
         end
         if (req_valid && req_ready) begin
            apply_palette_word(func_type'(req_func), req_entry_index, req_red, req_green,
                               req_blue, fresh);
            awaited_answers.push_back(fresh);
         end
      end
      in_flight = awaited_answers.size();
   end

endmodule

>>> verif/nearest_palette_color_mapper_unit_test.sv
`timescale 1ns / 1ps

module nearest_palette_color_mapper_unit_test;
   import npcm_pkg::*;

   localparam int RANDOM_WORDS = 1620;
   localparam int CALM_TAIL    = 150;
   localparam int FILL_AT      = 400;
   localparam int CYCLE_LIMIT  = 3_000_000;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic [1:0]         req_func;
   logic [INDEX_W-1:0] req_entry_index;
   logic [COLOR_W-1:0] req_red;
   logic [COLOR_W-1:0] req_green;
   logic [COLOR_W-1:0] req_blue;
   logic               rsp_valid;
   logic               rsp_ready;
   logic [INDEX_W-1:0] rsp_best_index;
   logic [DIST_W-1:0]  rsp_min_dist;
   logic               rsp_added;
   logic               rsp_palette_full;
   logic [COUNT_W-1:0] rsp_learned_count;
   int                 mismatch_count;
   int                 words_in_flight;

   logic               idle_on;
   int                 stall_left;
   int                 cycle_count;
   int                 words_sent;
   logic [RGB_W-1:0]   seen_colors [$];

   nearest_palette_color_mapper_unit u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_func          (req_func),
      .req_entry_index   (req_entry_index),
      .req_red           (req_red),
      .req_green         (req_green),
      .req_blue          (req_blue),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_best_index    (rsp_best_index),
      .rsp_min_dist      (rsp_min_dist),
      .rsp_added         (rsp_added),
      .rsp_palette_full  (rsp_palette_full),
      .rsp_learned_count (rsp_learned_count)
   );

   nearest_palette_color_mapper_unit_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_func          (req_func),
      .req_entry_index   (req_entry_index),
      .req_red           (req_red),
      .req_green         (req_green),
      .req_blue          (req_blue),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_best_index    (rsp_best_index),
      .rsp_min_dist      (rsp_min_dist),
      .rsp_added         (rsp_added),
      .rsp_palette_full  (rsp_palette_full),
      .rsp_learned_count (rsp_learned_count),
      .mismatch_count    (mismatch_count),
      .words_in_flight   (words_in_flight)
   );

   always #6 clock = ~clock;

   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b1;
      end else if (stall_left > 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= $urandom_range(0, 5);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("nearest_palette_color_mapper_unit_test failed");
         $finish;
      end
   end

   // Called at a falling edge; returns at the falling edge after the word is taken.
   task automatic send_word(input func_type f, input logic [7:0] idx, input logic [7:0] r,
                            input logic [7:0] g, input logic [7:0] b);
      int gap;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 6);
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_func        <= f;
      req_entry_index <= idx;
      req_red         <= r;
      req_green       <= g;
      req_blue        <= b;
      do @(posedge clock); while (!(req_valid && req_ready));
      @(negedge clock);
      words_sent++;
      if (f == FUNC_CLEAR) begin
         seen_colors.delete();
      end else if (f != FUNC_MAP) begin
         seen_colors.push_back({r, g, b});
         if (seen_colors.size() > 300) void'(seen_colors.pop_front());
      end
   endtask

   task automatic wait_drain();
      req_valid <= 1'b0;
      while (words_in_flight != 0) @(negedge clock);
   endtask

   function automatic logic [7:0] nudge(input logic [7:0] c);
      int v;
      v = int'(c) + int'($urandom_range(0, 6)) - 3;
      if (v < 0) v = 0;
      if (v > 255) v = 255;
      return v[7:0];
   endfunction

   // Mostly colors already in the palette or close to them, so learn hits matches and
   // map lands on near ties; the rest is noise and channel extremes.
   task automatic pick_color(output logic [7:0] r, output logic [7:0] g, output logic [7:0] b);
      int               mode;
      logic [RGB_W-1:0] base;
      mode = $urandom_range(0, 9);
      if (seen_colors.size() == 0 || mode < 3) begin
         r = 8'($urandom);
         g = 8'($urandom);
         b = 8'($urandom);
         if (mode == 0) begin
            r = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            g = $urandom_range(0, 1) ? 8'hFF : 8'h00;
         end
      end else begin
         base = seen_colors[$urandom_range(0, seen_colors.size() - 1)];
         r = base[23:16];
         g = base[15:8];
         b = base[7:0];
         if (mode >= 7) begin
            r = nudge(r);
            g = nudge(g);
            b = nudge(b);
         end
      end
   endtask

   task automatic random_word();
      int         roll;
      func_type   f;
      logic [7:0] idx;
      logic [7:0] r;
      logic [7:0] g;
      logic [7:0] b;
      roll = $urandom_range(0, 99);
      pick_color(r, g, b);
      idx = $urandom_range(0, 1) ? 8'($urandom) : 8'($urandom_range(0, 15));
      if (roll < 3) f = FUNC_CLEAR;
      else if (roll < 23) f = FUNC_WRITE;
      else if (roll < 58) f = FUNC_LEARN;
      else f = FUNC_MAP;
      send_word(f, idx, r, g, b);
   endtask

   // Learns a full palette of distinct colors, then tries more learns and some maps while it is full.
   task automatic fill_palette();
      logic [7:0] r;
      logic [7:0] g;
      logic [7:0] b;
      send_word(FUNC_CLEAR, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
      for (int i = 0; i < 256; i++) begin
         send_word(FUNC_LEARN, 8'($urandom), 8'(i), 8'($urandom), 8'($urandom));
      end
      repeat (8) begin
         pick_color(r, g, b);
         send_word(FUNC_LEARN, 8'($urandom), r, g, b);
      end
      repeat (6) begin
         pick_color(r, g, b);
         send_word(FUNC_MAP, 8'($urandom), r, g, b);
      end
   endtask

   initial begin
      int   target;
      logic filled;
      clock           = 1'b0;
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_func        = FUNC_CLEAR;
      req_entry_index = '0;
      req_red         = '0;
      req_green       = '0;
      req_blue        = '0;
      rsp_ready       = 1'b0;
      idle_on         = 1'b0;
      stall_left      = 0;
      cycle_count     = 0;
      words_sent      = 0;
      filled          = 1'b0;
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // All-zero palette, then a white entry at the top slot and a tie with slot zero.
      send_word(FUNC_MAP, 8'h00, 8'h00, 8'h00, 8'h00);
      send_word(FUNC_MAP, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
      send_word(FUNC_WRITE, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
      send_word(FUNC_MAP, 8'h13, 8'hFF, 8'hFF, 8'hFF);
      send_word(FUNC_MAP, 8'h00, 8'h80, 8'h80, 8'h80);
      send_word(FUNC_WRITE, 8'h00, 8'hFF, 8'hFF, 8'hFF);
      send_word(FUNC_MAP, 8'h00, 8'hFF, 8'hFF, 8'hFF);
      send_word(FUNC_MAP, 8'h00, 8'hFA, 8'hFF, 8'hFF);
      // Learning overwrites slot zero; a repeat is a match; a write leaves the count alone.
      send_word(FUNC_LEARN, 8'h00, 8'd10, 8'd20, 8'd30);
      send_word(FUNC_LEARN, 8'hFF, 8'd10, 8'd20, 8'd30);
      send_word(FUNC_WRITE, 8'h01, 8'd10, 8'd20, 8'd30);
      send_word(FUNC_LEARN, 8'h00, 8'd40, 8'd50, 8'd60);
      send_word(FUNC_WRITE, 8'h00, 8'd40, 8'd50, 8'd60);
      send_word(FUNC_LEARN, 8'h00, 8'd40, 8'd50, 8'd60);
      send_word(FUNC_WRITE, 8'hAA, 8'hAA, 8'h55, 8'hAA);
      send_word(FUNC_WRITE, 8'h55, 8'h55, 8'hAA, 8'h55);
      send_word(FUNC_MAP, 8'h00, 8'h00, 8'hFF, 8'h00);
      send_word(FUNC_MAP, 8'h00, 8'hAA, 8'h55, 8'hAB);
      // After a clear nothing counts as learned, so black is added rather than matched.
      send_word(FUNC_CLEAR, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
      send_word(FUNC_MAP, 8'h00, 8'd1, 8'd2, 8'd3);
      send_word(FUNC_LEARN, 8'h00, 8'h00, 8'h00, 8'h00);
      send_word(FUNC_LEARN, 8'h00, 8'h00, 8'h00, 8'h00);
      send_word(FUNC_WRITE, 8'h03, 8'h00, 8'h00, 8'h00);
      send_word(FUNC_MAP, 8'h00, 8'h00, 8'h00, 8'h00);
      send_word(FUNC_CLEAR, 8'h00, 8'h00, 8'h00, 8'h00);

      target = words_sent + RANDOM_WORDS;
      while (words_sent < target) begin
         if (!filled && words_sent >= FILL_AT) begin
            wait_drain();
            idle_on = 1'b1;
            fill_palette();
            filled = 1'b1;
         end
         idle_on = (target - words_sent > CALM_TAIL) && ($urandom_range(0, 3) != 0);
         repeat ($urandom_range(5, 30)) random_word();
      end

      wait_drain();
      repeat (20) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("nearest_palette_color_mapper_unit_test passed");
      end else begin
         $display("nearest_palette_color_mapper_unit_test failed");
      end
      $finish;
   end

endmodule
